// ----- rtl/core/kgram_markov_count_and_sample_assert.svh -----
`ifndef KGRAM_MARKOV_COUNT_AND_SAMPLE_ASSERT_SVH
`define KGRAM_MARKOV_COUNT_AND_SAMPLE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KMCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define KMCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/kmcs_pkg.sv -----
`timescale 1ns / 1ps
package kmcs_pkg;

  localparam int unsigned MAX_ORDER_DEF    = 7;
  localparam int unsigned GRAM_ENTRIES_DEF = 1024;
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned KEY_W            = 56;
  localparam int unsigned KEY_BYTES        = 7;

  typedef enum logic [2:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_CLOSE  = 3'd1,
    FUNC_TOTAL  = 3'd2,
    FUNC_FOLLOW = 3'd3,
    FUNC_SAMPLE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_CLOSE,
    OP_TOTAL,
    OP_FOLLOW,
    OP_SAMPLE,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SAT       = 2'd3
  } st_e;

  typedef enum logic [3:0] {
    BK_FETCH,
    BK_SRCH_RD,
    BK_SRCH_CMP,
    BK_CLR,
    BK_RD,
    BK_CNT_UPD,
    BK_FEED_END,
    BK_Q_OUT,
    BK_SMP_TOT,
    BK_MOD,
    BK_WALK_A,
    BK_WALK_B,
    BK_WALK_C,
    BK_WALK_D,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [7:0]       char_in;
    logic [KEY_W-1:0] kgram;
    logic [31:0]      rand_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  result_char;
    logic [15:0] count;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [2:0]       k;
    logic [7:0]       ch;
    logic [KEY_W-1:0] key;
    logic [31:0]      rnd;
  } cmd_t;

  function automatic logic [KEY_W-1:0] win_mask(input logic [2:0] k);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (3'(i) < k) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/kgram_markov_count_and_sample.sv -----
`timescale 1ns / 1ps
// A direct answer needs no table access; a lookup (query or count update) compares the
// stored k-grams one by one; a k-gram first seen by a count update first has its row zeroed;
// close repeats the count path once per kept byte.
// Sample: a lookup, then a walk over the alphabet entries in order.
// Throughput: one item at a time in the back end; a 2-entry queue and an output register
// decouple both sides. Reset: asynchronous, active low; clears control, counters and flags.
module kgram_markov_count_and_sample #(
  parameter int unsigned MAX_ORDER    = kmcs_pkg::MAX_ORDER_DEF,
  parameter int unsigned GRAM_ENTRIES = kmcs_pkg::GRAM_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS   = kmcs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kmcs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kmcs_pkg::out_item_t out_item_o
);
  import kmcs_pkg::*;

  logic [2:0] order_q;
  logic       push, pop, q_full, q_valid;
  cmd_t       cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i;
    end
  end

  kmcs_front #(
    .MAX_ORDER(MAX_ORDER)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .order_i   (order_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  kmcs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .full_o (q_full),
    .valid_o(q_valid)
  );

  kmcs_back #(
    .GRAM_ENTRIES(GRAM_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (pop),
    .cmd_i      (cmd_out),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- rtl/core/kmcs_front.sv -----
`timescale 1ns / 1ps
module kmcs_front #(
  parameter int unsigned MAX_ORDER = kmcs_pkg::MAX_ORDER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         order_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kmcs_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output kmcs_pkg::cmd_t     cmd_o
);
  import kmcs_pkg::*;

  logic [2:0] k_eff;
  logic       busy_q;

  assign k_eff      = (order_i > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_i;
  assign in_ready_o = !q_full_i && rst_ni && busy_q;
  assign push_o     = in_valid_i && in_ready_o;

  // open the input from the cycle after reset release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= 1'b1;
    end
  end

  always_comb begin
    cmd_o.k   = k_eff;
    cmd_o.ch  = in_item_i.char_in;
    cmd_o.key = in_item_i.kgram & win_mask(k_eff);
    cmd_o.rnd = in_item_i.rand_value;
    unique case (in_item_i.func)
      FUNC_LOAD:   cmd_o.op = OP_LOAD;
      FUNC_CLOSE:  cmd_o.op = OP_CLOSE;
      FUNC_TOTAL:  cmd_o.op = OP_TOTAL;
      FUNC_FOLLOW: cmd_o.op = OP_FOLLOW;
      FUNC_SAMPLE: cmd_o.op = OP_SAMPLE;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/core/kmcs_queue.sv -----
`timescale 1ns / 1ps
module kmcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kmcs_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output kmcs_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           valid_o
);
  import kmcs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] fill_q, fill_d;
  logic       do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = push_i ? !wr_q : wr_q;
    rd_d   = do_pop ? !rd_q : rd_q;
    fill_d = fill_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/kmcs_back.sv -----
`timescale 1ns / 1ps
module kmcs_back #(
  parameter int unsigned GRAM_ENTRIES = kmcs_pkg::GRAM_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS   = kmcs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  kmcs_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kmcs_pkg::out_item_t out_item_o
);
  import kmcs_pkg::*;

  localparam int unsigned EW = $clog2(GRAM_ENTRIES);
  localparam int unsigned CB = COUNT_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  function automatic logic [15:0] clip16(input logic [CB-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  logic [KEY_W-1:0] key_mem   [GRAM_ENTRIES];
  logic [CB-1:0]    tot_mem   [GRAM_ENTRIES];
  logic [CB-1:0]    cnt_mem   [GRAM_ENTRIES*256];
  logic [7:0]       alpha_mem [256];

  logic [KEY_W-1:0] key_rd_q;
  logic [CB-1:0]    tot_rd_q, cnt_rd_q;
  logic [7:0]       alpha_rd_q;

  bk_state_e        state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [EW:0]      entries_q, entries_d;
  logic [15:0]      len_q, len_d;
  logic [KEY_W-1:0] win_q, win_d;
  logic [KEY_W-1:0] first_q, first_d;
  logic [8:0]       asize_q, asize_d;
  logic [255:0]     seen_q, seen_d;
  logic [EW:0]      idx_q, idx_d;
  logic [EW-1:0]    ent_q, ent_d;
  logic [7:0]       lo_q, lo_d;
  logic [KEY_W-1:0] skey_q, skey_d;
  st_e              st_q, st_d;
  st_e              fst_q, fst_d;
  logic             lsat_q, lsat_d;
  logic [2:0]       ci_q, ci_d;
  logic [2:0]       cn_q, cn_d;
  logic [7:0]       clr_q, clr_d;
  logic [7:0]       rchar_q, rchar_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [CB-1:0]    tot_q, tot_d;
  logic [CB-1:0]    rem_q, rem_d;
  logic [4:0]       bit_q, bit_d;
  logic [CB:0]      roll_q, roll_d;
  logic [CB:0]      cum_q, cum_d;
  logic [8:0]       wi_q, wi_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             key_we;
  logic             tot_we;
  logic [EW-1:0]    tot_waddr;
  logic [CB-1:0]    tot_wdata;
  logic             cnt_we;
  logic [EW+7:0]    cnt_waddr;
  logic [CB-1:0]    cnt_wdata;
  logic             alpha_we;

  logic [KEY_W-1:0] mask_in, mask_cur, nwin;
  logic [2:0]       ci_nx;
  logic [CB:0]      sh;
  logic [CB-1:0]    rem_nx;
  logic [CB:0]      cum_nx;
  st_e              fs;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    mask_in  = win_mask(cmd_i.k);
    mask_cur = win_mask(cmd_q.k);
    nwin     = ((win_q << 8) | KEY_W'(lo_q)) & mask_cur;
    ci_nx    = ci_q + 3'd1;
    sh       = {rem_q, cmd_q.rnd[bit_q]};
    rem_nx   = (sh >= {1'b0, tot_q}) ? CB'(sh - {1'b0, tot_q}) : CB'(sh);
    cum_nx   = cum_q + {1'b0, cnt_rd_q};
    fs       = (st_q == ST_OK) ? fst_q : st_q;

    state_d     = state_q;
    cmd_d       = cmd_q;
    entries_d   = entries_q;
    len_d       = len_q;
    win_d       = win_q;
    first_d     = first_q;
    asize_d     = asize_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    lo_d        = lo_q;
    skey_d      = skey_q;
    st_d        = st_q;
    fst_d       = fst_q;
    lsat_d      = lsat_q;
    ci_d        = ci_q;
    cn_d        = cn_q;
    clr_d       = clr_q;
    rchar_d     = rchar_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    roll_d      = roll_q;
    cum_d       = cum_q;
    wi_d        = wi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    key_we      = 1'b0;
    tot_we      = 1'b0;
    tot_waddr   = ent_q;
    tot_wdata   = '0;
    cnt_we      = 1'b0;
    cnt_waddr   = {ent_q, lo_q};
    cnt_wdata   = '0;
    alpha_we    = 1'b0;

    unique case (state_q)
      BK_FETCH: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = cmd_i;
          st_d    = ST_OK;
          rchar_d = '0;
          cnt_d   = '0;
          idx_d   = '0;
          unique case (cmd_i.op)
            OP_LOAD: begin
              lsat_d = (len_q == 16'hFFFF);
              if (len_q != 16'hFFFF) begin
                len_d = len_q + 16'd1;
              end
              if (len_q < 16'(cmd_i.k)) begin
                first_d = first_q | (KEY_W'(cmd_i.ch) << {len_q[2:0], 3'b000});
                win_d   = ((win_q << 8) | KEY_W'(cmd_i.ch)) & mask_in;
                st_d    = (len_q == 16'hFFFF) ? ST_SAT : ST_OK;
                state_d = BK_DONE;
              end else begin
                lo_d    = cmd_i.ch;
                skey_d  = win_q & mask_in;
                state_d = BK_SRCH_RD;
              end
            end
            OP_CLOSE: begin
              cn_d    = (len_q < 16'(cmd_i.k)) ? len_q[2:0] : cmd_i.k;
              ci_d    = '0;
              lo_d    = first_q[7:0];
              skey_d  = win_q & mask_in;
              state_d = ((len_q == 16'd0) || (cmd_i.k == 3'd0)) ? BK_DONE : BK_SRCH_RD;
            end
            OP_TOTAL: begin
              skey_d = cmd_i.key;
              if (cmd_i.k == 3'd0) begin
                cnt_d   = len_q;
                state_d = BK_DONE;
              end else begin
                state_d = BK_SRCH_RD;
              end
            end
            OP_FOLLOW: begin
              skey_d  = cmd_i.key;
              lo_d    = cmd_i.ch;
              state_d = BK_SRCH_RD;
            end
            OP_SAMPLE: begin
              skey_d  = cmd_i.key;
              state_d = BK_SRCH_RD;
            end
            default: state_d = BK_DONE;
          endcase
        end
      end

      BK_SRCH_RD: begin
        if (idx_q == entries_q) begin
          case (cmd_q.op)
            OP_LOAD, OP_CLOSE: begin
              if (entries_q == (EW+1)'(GRAM_ENTRIES)) begin
                fst_d   = ST_FULL;
                state_d = BK_FEED_END;
              end else begin
                key_we    = 1'b1;
                tot_we    = 1'b1;
                tot_waddr = entries_q[EW-1:0];
                ent_d     = entries_q[EW-1:0];
                entries_d = entries_q + 1'b1;
                clr_d     = '0;
                state_d   = BK_CLR;
              end
            end
            default: begin
              st_d    = ST_NOT_FOUND;
              state_d = BK_DONE;
            end
          endcase
        end else begin
          state_d = BK_SRCH_CMP;
        end
      end

      BK_SRCH_CMP: begin
        if (key_rd_q == skey_q) begin
          ent_d   = idx_q[EW-1:0];
          state_d = BK_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = BK_SRCH_RD;
        end
      end

      BK_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = {ent_q, clr_q};
        clr_d     = clr_q + 8'd1;
        if (clr_q == 8'hFF) begin
          state_d = BK_RD;
        end
      end

      BK_RD: begin
        case (cmd_q.op)
          OP_LOAD, OP_CLOSE:    state_d = BK_CNT_UPD;
          OP_TOTAL, OP_FOLLOW:  state_d = BK_Q_OUT;
          OP_SAMPLE:            state_d = BK_SMP_TOT;
          default:              state_d = BK_DONE;
        endcase
      end

      BK_CNT_UPD: begin
        if ((tot_rd_q == CMAX) || (cnt_rd_q == CMAX)) begin
          fst_d = ST_SAT;
        end else begin
          fst_d     = ST_OK;
          tot_we    = 1'b1;
          tot_wdata = tot_rd_q + 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd_q + 1'b1;
          if (!seen_q[lo_q] && !asize_q[8]) begin
            seen_d[lo_q] = 1'b1;
            alpha_we     = 1'b1;
            asize_d      = asize_q + 9'd1;
          end
        end
        state_d = BK_FEED_END;
      end

      BK_FEED_END: begin
        win_d = nwin;
        if (cmd_q.op == OP_CLOSE) begin
          st_d = fs;
          if (ci_nx == cn_q) begin
            state_d = BK_DONE;
          end else begin
            ci_d    = ci_nx;
            lo_d    = first_q[{ci_nx, 3'b000} +: 8];
            skey_d  = nwin;
            idx_d   = '0;
            state_d = BK_SRCH_RD;
          end
        end else begin
          st_d    = ((fs == ST_OK) && lsat_q) ? ST_SAT : fs;
          state_d = BK_DONE;
        end
      end

      BK_Q_OUT: begin
        cnt_d   = (cmd_q.op == OP_TOTAL) ? clip16(tot_rd_q) : clip16(cnt_rd_q);
        state_d = BK_DONE;
      end

      BK_SMP_TOT: begin
        if (tot_rd_q == '0) begin
          st_d    = ST_NOT_FOUND;
          state_d = BK_DONE;
        end else begin
          tot_d   = tot_rd_q;
          rem_d   = '0;
          bit_d   = 5'd31;
          state_d = BK_MOD;
        end
      end

      BK_MOD: begin
        rem_d = rem_nx;
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          roll_d  = {1'b0, rem_nx} + 1'b1;
          cum_d   = '0;
          wi_d    = '0;
          state_d = BK_WALK_A;
        end
      end

      BK_WALK_A: begin
        if (wi_q == asize_q) begin
          st_d    = ST_NOT_FOUND;
          state_d = BK_DONE;
        end else begin
          state_d = BK_WALK_B;
        end
      end

      BK_WALK_B: begin
        lo_d    = alpha_rd_q;
        state_d = BK_WALK_C;
      end

      BK_WALK_C: state_d = BK_WALK_D;

      BK_WALK_D: begin
        cum_d = cum_nx;
        if (roll_q <= cum_nx) begin
          rchar_d = lo_q;
          cnt_d   = clip16(tot_q);
          state_d = BK_DONE;
        end else begin
          wi_d    = wi_q + 9'd1;
          state_d = BK_WALK_A;
        end
      end

      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.result_char = rchar_q;
          out_d.count       = cnt_q;
          out_d.status      = st_q;
          state_d           = BK_FETCH;
        end
      end

      default: state_d = BK_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FETCH;
      entries_q   <= '0;
      len_q       <= '0;
      win_q       <= '0;
      first_q     <= '0;
      asize_q     <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      entries_q   <= entries_d;
      len_q       <= len_d;
      win_q       <= win_d;
      first_q     <= first_d;
      asize_q     <= asize_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    ent_q   <= ent_d;
    lo_q    <= lo_d;
    skey_q  <= skey_d;
    st_q    <= st_d;
    fst_q   <= fst_d;
    lsat_q  <= lsat_d;
    ci_q    <= ci_d;
    cn_q    <= cn_d;
    clr_q   <= clr_d;
    rchar_q <= rchar_d;
    cnt_q   <= cnt_d;
    tot_q   <= tot_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    roll_q  <= roll_d;
    cum_q   <= cum_d;
    wi_q    <= wi_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[idx_q[EW-1:0]];
    if (key_we) begin
      key_mem[entries_q[EW-1:0]] <= skey_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_rd_q <= tot_mem[ent_q];
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[{ent_q, lo_q}];
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_rd_q <= alpha_mem[wi_q[7:0]];
    if (alpha_we) begin
      alpha_mem[asize_q[7:0]] <= lo_q;
    end
  end

endmodule

// ----- rtl/core/kmcs_checker.sv -----
`timescale 1ns / 1ps
`include "kgram_markov_count_and_sample_assert.svh"
module kmcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input kmcs_pkg::out_item_t out_item_o
);
  import kmcs_pkg::*;

  `KMCS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result item dropped or changed while stalled")
  `KMCS_ASSERT_IMP(a_err_clean, out_valid_o && (out_item_o.status != ST_OK), (out_item_o.result_char == 8'd0) && (out_item_o.count == 16'd0), "error item carries data")
  `KMCS_ASSERT_IMP(a_char_total, out_valid_o && (out_item_o.result_char != 8'd0), out_item_o.count != 16'd0, "sampled byte without total")

endmodule

bind kgram_markov_count_and_sample kmcs_checker u_kmcs_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import kmcs_pkg::*;

  localparam int unsigned NGRAM   = 1024;
  localparam int unsigned WDOG    = 60000;
  localparam int unsigned N_ITEMS = 1600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  kgram_markov_count_and_sample dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #2 clk_i = ~clk_i;

  // model state
  logic [2:0]  m_order;
  logic [55:0] m_key [NGRAM];
  bit          m_kval [NGRAM];
  bit [15:0]   m_fol [NGRAM*256];
  bit [15:0]   m_tot [NGRAM];
  bit [7:0]    m_alpha [256];
  bit          m_seen [256];
  int unsigned m_alpha_n;
  int unsigned m_len;
  logic [55:0] m_win;
  logic [55:0] m_head;
  int unsigned m_used;

  out_item_t   exp_q [$];
  byte unsigned text_hist [$];
  int          n_bad = 0;
  int          n_items = 0;
  bit          no_idle = 1'b0;

  bit          in_hs = 1'b0;
  bit          out_hs = 1'b0;
  out_item_t   out_smp;

  // capture the handshakes once inputs have settled, ahead of the rising edge
  always @(negedge clk_i) begin
    #1;
    in_hs   = in_valid && in_ready;
    out_hs  = rst_ni && out_valid && out_ready;
    out_smp = out_item;
  end

  function automatic logic [55:0] kmask(input int unsigned k);
    logic [63:0] m;
    m = (k == 0) ? 64'd0 : ((64'd1 << (8 * k)) - 64'd1);
    return m[55:0];
  endfunction

  function automatic int find_gram(input logic [55:0] key);
    for (int i = 0; i < m_used && i < NGRAM; i++) begin
      if (m_kval[i] && m_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic st_e bump_follower(input logic [55:0] key, input bit [7:0] b);
    int e;
    int unsigned idx;
    e = find_gram(key);
    if (e < 0) begin
      if (m_used >= NGRAM) return ST_FULL;
      e = m_used;
      m_key[e] = key;
      m_kval[e] = 1'b1;
      m_tot[e] = '0;
      m_used++;
    end
    idx = e * 256 + b;
    if (m_tot[e] == 16'hFFFF || m_fol[idx] == 16'hFFFF) return ST_SAT;
    m_tot[e]++;
    m_fol[idx]++;
    if (!m_seen[b] && m_alpha_n < 256) begin
      m_seen[b] = 1'b1;
      m_alpha[m_alpha_n] = b;
      m_alpha_n++;
    end
    return ST_OK;
  endfunction

  function automatic st_e shift_in(input bit [7:0] b, input int unsigned k);
    st_e s;
    s = bump_follower(m_win & kmask(k), b);
    m_win = ((m_win << 8) | 56'(b)) & kmask(k);
    return s;
  endfunction

  function automatic out_item_t predict_markov(input in_item_t it);
    out_item_t   r;
    int unsigned k, pos, n;
    logic [55:0] key;
    logic [63:0] roll, cum, tot;
    int          e;
    st_e         s;
    bit          hit, lsat;
    r = '0;
    k = m_order;
    key = it.kgram & kmask(k);
    case (it.func)
      FUNC_LOAD: begin
        pos = m_len;
        lsat = (m_len >= 65535);
        if (!lsat) m_len++;
        if (pos < k) begin
          m_head |= 56'(it.char_in) << (8 * pos);
          m_win = ((m_win << 8) | 56'(it.char_in)) & kmask(k);
        end else begin
          r.status = shift_in(it.char_in, k);
        end
        if (r.status == ST_OK && lsat) r.status = ST_SAT;
      end
      FUNC_CLOSE: begin
        n = (m_len < k) ? m_len : k;
        for (int i = 0; i < n; i++) begin
          s = shift_in(m_head[8*i +: 8], k);
          if (r.status == ST_OK) r.status = s;
        end
      end
      FUNC_TOTAL: begin
        if (k == 0) begin
          r.count = 16'(m_len);
        end else begin
          e = find_gram(key);
          if (e < 0) r.status = ST_NOT_FOUND;
          else r.count = m_tot[e];
        end
      end
      FUNC_FOLLOW: begin
        e = find_gram(key);
        if (e < 0) r.status = ST_NOT_FOUND;
        else r.count = m_fol[e * 256 + it.char_in];
      end
      FUNC_SAMPLE: begin
        e = find_gram(key);
        if (e < 0 || m_tot[e] == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tot = m_tot[e];
          roll = 64'd1 + (64'(it.rand_value) % tot);
          cum = 0;
          hit = 1'b0;
          for (int i = 0; i < m_alpha_n; i++) begin
            cum += m_fol[e * 256 + m_alpha[i]];
            if (!hit && roll <= cum) begin
              r.result_char = m_alpha[i];
              hit = 1'b1;
            end
          end
          if (hit) r.count = tot[15:0];
          else r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_order(input logic [2:0] v);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk_i); while (!cfg_ready);
    m_order = v;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // hold the item until accepted, then queue its expected result
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t p;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk_i); while (!in_hs);
    p = predict_markov(it);
    if (it.func == FUNC_LOAD) text_hist.push_back(it.char_in);
    exp_q.push_back(typed ? want : p);
    n_items++;
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  function automatic in_item_t mk(input logic [2:0] f, input logic [7:0] c,
                                  input logic [55:0] g, input logic [31:0] rv);
    in_item_t it;
    it.func = f;
    it.char_in = c;
    it.kgram = g;
    it.rand_value = rv;
    return it;
  endfunction

  function automatic out_item_t ro(input logic [7:0] c, input logic [15:0] n, input st_e s);
    out_item_t r;
    r.result_char = c;
    r.count = n;
    r.status = s;
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'($urandom);
    if (r < 35) return 8'h00;
    if (r < 68) return 8'hFF;
    return 8'h5A;
  endfunction

  function automatic logic [55:0] pick_key(input int unsigned k);
    logic [55:0] key, junk;
    int unsigned p;
    key = '0;
    if (text_hist.size() >= k && $urandom_range(0, 9) < 8) begin
      p = $urandom_range(0, text_hist.size() - k);
      for (int j = 0; j < k; j++) key = (key << 8) | 56'(text_hist[p + j]);
    end else begin
      key = {$urandom, $urandom};
    end
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1)) key |= junk & ~kmask(k);
    return key;
  endfunction

  typedef struct {
    bit        is_cfg;
    logic [2:0] cfg_v;
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;

  row_t plan [$];

  // accept results and compare
  always @(posedge clk_i) begin
    if (out_hs) begin
      if (exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected item: %h", out_smp);
      end else begin
        if (out_smp !== exp_q[0]) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp char %h count %0d status %0d, got char %h count %0d status %0d",
                     exp_q[0].result_char, exp_q[0].count, exp_q[0].status,
                     out_smp.result_char, out_smp.count, out_smp.status);
        end
        void'(exp_q.pop_front());
      end
    end
  end

  initial begin
    int unsigned w;
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ready = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_hs);
      @(negedge clk_i);
    end
  end

  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if (in_hs || out_hs || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned k, tl;
    in_item_t it;
    m_order = '0;
    m_alpha_n = 0;
    m_len = 0;
    m_win = '0;
    m_head = '0;
    m_used = 0;
    for (int i = 0; i < NGRAM; i++) begin
      m_kval[i] = 1'b0;
      m_tot[i] = '0;
    end
    for (int i = 0; i < 256; i++) m_seen[i] = 1'b0;

    plan.push_back('{0, 0, mk(FUNC_TOTAL, 0, 0, 0), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_FOLLOW, 0, 0, 0), 1, ro(0, 0, ST_NOT_FOUND)});
    plan.push_back('{0, 0, mk(FUNC_SAMPLE, 0, 0, 0), 1, ro(0, 0, ST_NOT_FOUND)});
    plan.push_back('{0, 0, mk(3'd5, 8'hFF, '1, '1), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(3'd6, 8'h00, '0, '0), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(3'd7, 8'hA5, '1, '1), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_LOAD, 8'h00, 0, 0), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_LOAD, 8'hFF, '1, '1), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_TOTAL, 0, 0, 0), 1, ro(0, 2, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_FOLLOW, 8'hFF, 0, 0), 1, ro(0, 1, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_SAMPLE, 0, 0, 0), 1, ro(8'h00, 2, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_SAMPLE, 0, 0, '1), 1, ro(8'hFF, 2, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_CLOSE, 0, 0, 0), 1, ro(0, 0, ST_OK)});
    plan.push_back('{0, 0, mk(FUNC_TOTAL, 0, '1, 0), 1, ro(0, 2, ST_OK)});
    plan.push_back('{1, 3'd7, '0, 0, '0});
    plan.push_back('{0, 0, mk(FUNC_LOAD, 8'h41, 0, 0), 0, '0});
    plan.push_back('{0, 0, mk(FUNC_CLOSE, 0, 0, 0), 0, '0});
    plan.push_back('{0, 0, mk(FUNC_TOTAL, 0, 56'h0000_00FF_0000_00, 0), 0, '0});
    plan.push_back('{0, 0, mk(FUNC_SAMPLE, 0, 56'h0, 32'h1234_5678), 0, '0});
    plan.push_back('{1, 3'd1, '0, 0, '0});
    plan.push_back('{0, 0, mk(FUNC_LOAD, 8'h00, 0, 0), 0, '0});
    plan.push_back('{0, 0, mk(FUNC_FOLLOW, 8'h00, 56'h41, 0), 0, '0});
    plan.push_back('{0, 0, mk(FUNC_SAMPLE, 0, 56'hFF, '1), 0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_order(plan[i].cfg_v);
      else send_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    while (n_items < N_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      w_ord: begin
        int unsigned r;
        r = $urandom_range(0, 9);
        k = (r < 3) ? 0 : (r < 6) ? 1 : (r < 8) ? 2 : (r < 9) ? 3 : $urandom_range(4, 7);
      end
      write_order(k[2:0]);
      tl = $urandom_range(8, 24);
      for (int i = 0; i < tl; i++) send_item(mk(FUNC_LOAD, pick_char(), pick_key(k), $urandom),
                                             0, '0);
      if ($urandom_range(0, 2) != 0)
        send_item(mk(FUNC_CLOSE, pick_char(), pick_key(k), $urandom), 0, '0);
      for (int i = 0; i < 30; i++) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        it = mk(FUNC_SAMPLE, pick_char(), pick_key(k), $urandom);
        if (r < 25) it.func = FUNC_TOTAL;
        else if (r < 55) it.func = FUNC_FOLLOW;
        else if (r < 88) it.func = FUNC_SAMPLE;
        else if (r < 93) it.func = FUNC_LOAD;
        else if (r < 96) it.func = FUNC_CLOSE;
        else it.func = 3'($urandom_range(5, 7));
        send_item(it, 0, '0);
      end
    end

    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_bad == 0 && exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- kgram_markov_count_and_sample.f -----
+incdir+rtl/core
rtl/core/kmcs_pkg.sv
rtl/core/kmcs_front.sv
rtl/core/kmcs_queue.sv
rtl/core/kmcs_back.sv
rtl/core/kgram_markov_count_and_sample.sv
rtl/core/kmcs_checker.sv
dv/tb.sv
